// ===== rtl/mi3_pkg.sv =====
// Shared constants and types for the 3x3 matrix inverse core.
package mi3_pkg;

    localparam int IN_WIDTH_DEF  = 16;
    localparam int OUT_WIDTH_DEF = 32;
    localparam int IN_FRAC       = 12;
    localparam int OUT_FRAC      = 16;
    localparam int ACC_W         = 64;
    localparam int SCALE_SH      = IN_FRAC + OUT_FRAC;
    localparam int COF_LAT       = 4;

    typedef logic [ACC_W-1:0] acc_t;

endpackage

// ===== rtl/mi3_cofactor.sv =====
// Minors, adjugate and determinant pipeline (four register stages).
module mi3_cofactor
    import mi3_pkg::*;
#(
    parameter int IN_WIDTH = IN_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  adv,
    input  logic [9*IN_WIDTH-1:0] elem,
    output acc_t                  adj [9],
    output acc_t                  det
);

    localparam int PW = 2 * IN_WIDTH;

    logic signed [IN_WIDTH-1:0] e [3][3];
    logic signed [PW-1:0]       prod_a_reg [3][3];
    logic signed [PW-1:0]       prod_b_reg [3][3];
    logic signed [PW-1:0]       prod_a_next [3][3];
    logic signed [PW-1:0]       prod_b_next [3][3];
    logic signed [IN_WIDTH-1:0] row0_s1_reg [3];
    logic signed [IN_WIDTH-1:0] row0_s2_reg [3];
    acc_t                       minor_reg [3][3];
    acc_t                       minor_s3_reg [3][3];
    logic signed [IN_WIDTH+32:0] plo_reg [3];
    logic signed [IN_WIDTH+31:0] phi_reg [3];
    logic signed [IN_WIDTH+32:0] plo_next [3];
    logic signed [IN_WIDTH+31:0] phi_next [3];
    acc_t                       term [3];
    acc_t                       adj_reg [9];
    acc_t                       det_reg;

    genvar r, c;
    generate
        for (r = 0; r < 3; r++) begin : g_row
            for (c = 0; c < 3; c++) begin : g_col
                localparam int A = (r == 0) ? 1 : 0;
                localparam int B = (r == 2) ? 1 : 2;
                localparam int P = (c == 0) ? 1 : 0;
                localparam int Q = (c == 2) ? 1 : 2;
                assign e[r][c] = $signed(elem[(r*3+c)*IN_WIDTH +: IN_WIDTH]);
                assign prod_a_next[r][c] = e[A][P] * e[B][Q];
                assign prod_b_next[r][c] = e[A][Q] * e[B][P];
            end
        end
        for (c = 0; c < 3; c++) begin : g_det
            logic signed [32:0] lo;
            logic signed [31:0] hi;
            assign lo = $signed({1'b0, minor_reg[0][c][31:0]});
            assign hi = $signed(minor_reg[0][c][63:32]);
            assign plo_next[c] = row0_s2_reg[c] * lo;
            assign phi_next[c] = row0_s2_reg[c] * hi;
            assign term[c] = ACC_W'(plo_reg[c]) + (ACC_W'(phi_reg[c]) << 32);
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                row0_s1_reg[i] <= e[0][i];
                row0_s2_reg[i] <= row0_s1_reg[i];
                plo_reg[i]     <= plo_next[i];
                phi_reg[i]     <= phi_next[i];
                for (int j = 0; j < 3; j++) begin
                    prod_a_reg[i][j]   <= prod_a_next[i][j];
                    prod_b_reg[i][j]   <= prod_b_next[i][j];
                    minor_reg[i][j]    <= ACC_W'(prod_a_reg[i][j]) - ACC_W'(prod_b_reg[i][j]);
                    minor_s3_reg[i][j] <= minor_reg[i][j];
                    if (((i + j) % 2) == 1) begin
                        adj_reg[i*3+j] <= ACC_W'(0) - minor_s3_reg[j][i];
                    end else begin
                        adj_reg[i*3+j] <= minor_s3_reg[j][i];
                    end
                end
            end
            det_reg <= term[0] - term[1] + term[2];
        end
    end

    assign adj = adj_reg;
    assign det = det_reg;

endmodule

// ===== rtl/mi3_divider.sv =====
// Nine-lane pipelined restoring divider with saturation, one quotient bit per stage.
module mi3_divider
    import mi3_pkg::*;
#(
    parameter int OUT_WIDTH = OUT_WIDTH_DEF
) (
    input  logic                 aclk,
    input  logic                 adv,
    input  acc_t                 num [9],
    input  acc_t                 den,
    output logic [OUT_WIDTH-1:0] quo [9],
    output logic                 sing
);

    localparam int WW = ACC_W + OUT_WIDTH;
    localparam int NS = OUT_WIDTH + 1;

    typedef struct packed {
        logic neg;
        logic sat;
    } lane_flags_t;

    acc_t                 d_reg    [NS];
    logic                 sing_reg [NS];
    acc_t                 rem_reg  [NS][9];
    logic [OUT_WIDTH-1:0] q_reg    [NS][9];
    lane_flags_t          flg_reg  [NS][9];
    logic [OUT_WIDTH-1:0] quo_reg  [9];
    logic                 sing_out_reg;

    acc_t                 d_abs;
    acc_t                 n_abs    [9];
    lane_flags_t          flg_next [9];

    always_comb begin
        d_abs = den[ACC_W-1] ? ACC_W'(0) - den : den;
        for (int l = 0; l < 9; l++) begin
            n_abs[l] = (num[l][ACC_W-1] ? ACC_W'(0) - num[l] : num[l]) << SCALE_SH;
            flg_next[l].neg = num[l][ACC_W-1] ^ den[ACC_W-1];
            flg_next[l].sat = WW'(n_abs[l]) >= (WW'(d_abs) << OUT_WIDTH);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            d_reg[0]    <= d_abs;
            sing_reg[0] <= (den == ACC_W'(0));
            for (int l = 0; l < 9; l++) begin
                rem_reg[0][l] <= n_abs[l];
                q_reg[0][l]   <= '0;
                flg_reg[0][l] <= flg_next[l];
            end
        end
    end

    genvar s, l;
    generate
        for (s = 0; s < OUT_WIDTH; s++) begin : g_step
            localparam int K = OUT_WIDTH - 1 - s;
            logic [WW-1:0] dsh;
            assign dsh = WW'(d_reg[s]) << K;
            for (l = 0; l < 9; l++) begin : g_lane
                logic ge;
                assign ge = WW'(rem_reg[s][l]) >= dsh;
                always_ff @(posedge aclk) begin
                    if (adv) begin
                        rem_reg[s+1][l] <= ge ? rem_reg[s][l] - dsh[ACC_W-1:0] : rem_reg[s][l];
                        q_reg[s+1][l]   <= q_reg[s][l] | (OUT_WIDTH'(ge) << K);
                        flg_reg[s+1][l] <= flg_reg[s][l];
                    end
                end
            end
            always_ff @(posedge aclk) begin
                if (adv) begin
                    d_reg[s+1]    <= d_reg[s];
                    sing_reg[s+1] <= sing_reg[s];
                end
            end
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (adv) begin
            sing_out_reg <= sing_reg[NS-1];
            for (int i = 0; i < 9; i++) begin
                logic [OUT_WIDTH-1:0] qv;
                logic                 over;
                qv   = q_reg[NS-1][i];
                over = flg_reg[NS-1][i].neg ? (qv[OUT_WIDTH-1] && (|qv[OUT_WIDTH-2:0]))
                                            : qv[OUT_WIDTH-1];
                if (flg_reg[NS-1][i].sat || over) begin
                    qv = flg_reg[NS-1][i].neg ? {1'b1, {(OUT_WIDTH-1){1'b0}}}
                                              : {1'b0, {(OUT_WIDTH-1){1'b1}}};
                end
                if (sing_reg[NS-1]) begin
                    quo_reg[i] <= '0;
                end else if (flg_reg[NS-1][i].neg) begin
                    quo_reg[i] <= OUT_WIDTH'(0) - qv;
                end else begin
                    quo_reg[i] <= qv;
                end
            end
        end
    end

    assign quo  = quo_reg;
    assign sing = sing_out_reg;

endmodule

// ===== rtl/matrix3x3_inverse_core.sv =====
// Top level of the pipelined 3x3 matrix inverse core.
// Takes one 3x3 matrix of signed Q4.12 elements per transaction and returns its inverse as
// nine signed Q16.16 entries, saturated, with tuser set when the determinant is zero (all
// entries then zero). One matrix is accepted every cycle while the pipeline is not held;
// each passes the cofactor and determinant stages, then a divider stage per quotient bit.
// The whole pipeline holds while the result register is full and not taken.
module matrix3x3_inverse_core
    import mi3_pkg::*;
#(
    parameter int IN_WIDTH  = IN_WIDTH_DEF,
    parameter int OUT_WIDTH = OUT_WIDTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // m00 m01 m02 m10 m11 m12 m20 m21 m22, zero padded
    input  logic [((9*IN_WIDTH+7)/8)*8-1:0]     s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // inv00 inv01 inv02 inv10 inv11 inv12 inv20 inv21 inv22, zero padded
    output logic [((9*OUT_WIDTH+7)/8)*8-1:0]    m_axis_tdata,
    // singular
    output logic                                m_axis_tuser
);

    localparam int LAT   = COF_LAT + OUT_WIDTH + 2;
    localparam int M_W   = ((9*OUT_WIDTH+7)/8)*8;

    logic                 adv;
    logic [LAT-1:0]       valid_reg;
    logic [LAT-1:0]       valid_next;
    acc_t                 adj [9];
    acc_t                 det;
    logic [OUT_WIDTH-1:0] quo [9];
    logic                 sing;
    logic [9*OUT_WIDTH-1:0] packed_q;

    assign adv           = ~valid_reg[LAT-1] | m_axis_tready;
    assign s_axis_tready = adv;
    assign valid_next    = {valid_reg[LAT-2:0], s_axis_tvalid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (adv) begin
            valid_reg <= valid_next;
        end
    end

    mi3_cofactor #(
        .IN_WIDTH (IN_WIDTH)
    ) u_cofactor (
        .aclk (aclk),
        .adv  (adv),
        .elem (s_axis_tdata[9*IN_WIDTH-1:0]),
        .adj  (adj),
        .det  (det)
    );

    mi3_divider #(
        .OUT_WIDTH (OUT_WIDTH)
    ) u_divider (
        .aclk (aclk),
        .adv  (adv),
        .num  (adj),
        .den  (det),
        .quo  (quo),
        .sing (sing)
    );

    always_comb begin
        for (int i = 0; i < 9; i++) begin
            packed_q[i*OUT_WIDTH +: OUT_WIDTH] = quo[i];
        end
    end

    assign m_axis_tvalid = valid_reg[LAT-1];
    assign m_axis_tdata  = M_W'(packed_q);
    assign m_axis_tuser  = sing;

endmodule
